[rtl/txc_pkg.sv]
// ============================================================================
// txc_pkg
// Shared types and codes for the text console writer: item structs, operation
// codes, character codes and the controller to datapath command and status.
// ============================================================================
package txc_pkg;

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int IDX_W    = 11;
    localparam int POS_W    = 11;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

    // memory write source
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_CHAR  = 2'd1;
    localparam logic [1:0] WR_BLANK = 2'd2;
    localparam logic [1:0] WR_COPY  = 2'd3;

    // memory read address source
    localparam logic [1:0] RD_NONE     = 2'd0;
    localparam logic [1:0] RD_IDX      = 2'd1;
    localparam logic [1:0] RD_SRC      = 2'd2;
    localparam logic [1:0] RD_SRC_NEXT = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } txc_in_t;

    typedef struct packed {
        logic [POS_W-1:0]   cursor_position;
        logic [CHAR_W-1:0]  read_char;
        logic [COLOR_W-1:0] read_color;
    } txc_out_t;

    typedef struct packed {
        logic       load;
        logic       cur_home;
        logic       cur_newline;
        logic       cur_advance;
        logic       ptr_clear;
        logic       ptr_inc;
        logic [1:0] wr_sel;
        logic [1:0] rd_sel;
        logic       result;
        logic       take_read;
    } txc_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            is_newline;
        logic            wrap_pending;
        logic            last_row;
        logic            idx_valid;
        logic            last_copy;
        logic            last_cell;
    } txc_stat_t;

endpackage

[rtl/txc_ram.sv]
// ============================================================================
// txc_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module txc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/txc_datapath.sv]
// ============================================================================
// txc_datapath
// Cursor, sweep pointer, color register, screen memory and result register.
// Acts on commands from the controller and reports status back.
// ============================================================================
module txc_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  txc_pkg::txc_in_t                    command,
    input  logic                                cfg_we,
    input  logic [txc_pkg::COLOR_W-1:0]         cfg_data,
    input  txc_pkg::txc_cmd_t                   cmd,
    output txc_pkg::txc_stat_t                  st,
    output logic                                done,
    output txc_pkg::txc_out_t                   result
);
    import txc_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int LW    = (PW > POS_W) ? PW : POS_W;
    localparam int IW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int DW    = CHAR_W + COLOR_W;

    localparam logic [LW-1:0] COLS_LW    = LW'(COLUMNS);
    localparam logic [IW-1:0] CELLS_IW   = IW'(CELLS);
    localparam logic [CW-1:0] COLS_CW    = CW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [AW-1:0] COLS_AW    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);

    txc_in_t             item_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [RW-1:0]       row_reg;
    logic [RW-1:0]       row_next;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic                done_reg;
    txc_out_t            result_reg;

    logic [LW-1:0]       lin;
    logic [IW-1:0]       idx_ext;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DW-1:0]       ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DW-1:0]       ram_rdata;

    assign lin     = LW'(row_reg) * COLS_LW + LW'(col_reg);
    assign idx_ext = IW'(item_reg.cell_index);

    assign st.operation    = item_reg.operation;
    assign st.is_newline   = (item_reg.char_code == NEWLINE_CODE);
    assign st.wrap_pending = (col_reg >= COLS_CW);
    assign st.last_row     = (row_reg == LAST_ROW);
    assign st.idx_valid    = (idx_ext < CELLS_IW);
    assign st.last_copy    = (ptr_reg == LAST_COPY);
    assign st.last_cell    = (ptr_reg == LAST_CELL);

    // cursor and sweep pointer
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        ptr_next = ptr_reg;
        if (cmd.cur_home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.cur_newline)
        begin
            col_next = '0;
            if (row_reg != LAST_ROW)
            begin
                row_next = row_reg + RW'(1);
            end
        end
        else if (cmd.cur_advance)
        begin
            col_next = col_reg + CW'(1);
        end
        if (cmd.ptr_clear)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    // memory port selection
    always_comb
    begin
        ram_we    = (cmd.wr_sel != WR_NONE);
        ram_waddr = ptr_reg;
        ram_wdata = {color_reg, BLANK_CODE};
        case (cmd.wr_sel)
            WR_CHAR:
            begin
                ram_waddr = lin[AW-1:0];
                ram_wdata = {color_reg, item_reg.char_code};
            end
            WR_COPY:
            begin
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_waddr = ptr_reg;
            end
        endcase

        ram_re    = (cmd.rd_sel != RD_NONE);
        ram_raddr = idx_ext[AW-1:0];
        case (cmd.rd_sel)
            RD_SRC:      ram_raddr = ptr_reg + COLS_AW;
            RD_SRC_NEXT: ram_raddr = ptr_reg + COLS_AW + AW'(1);
            default:     ram_raddr = idx_ext[AW-1:0];
        endcase
    end

    txc_ram #(
        .WIDTH (DW),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_reg <= cfg_data;
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            ptr_reg  <= ptr_next;
            done_reg <= cmd.result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= command;
        end
        if (cmd.result)
        begin
            result_reg.cursor_position <= lin[POS_W-1:0];
            if (cmd.take_read)
            begin
                result_reg.read_char  <= ram_rdata[CHAR_W-1:0];
                result_reg.read_color <= ram_rdata[DW-1:CHAR_W];
            end
            else
            begin
                result_reg.read_char  <= '0;
                result_reg.read_color <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= LAST_ROW)
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COLS_CW)
        else $error("cursor column beyond pending wrap");

endmodule

[rtl/txc_ctrl.sv]
// ============================================================================
// txc_ctrl
// Controller state machine: decodes each item and sequences cursor updates,
// screen clear, scroll copy and fill, cell reads and the result strobe.
// ============================================================================
module txc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  txc_pkg::txc_stat_t  st,
    output txc_pkg::txc_cmd_t   cmd
);
    import txc_pkg::*;

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_DECODE      = 4'd1;
    localparam logic [3:0] S_WRITE       = 4'd2;
    localparam logic [3:0] S_CLEAR       = 4'd3;
    localparam logic [3:0] S_SCROLL_PRIME = 4'd4;
    localparam logic [3:0] S_SCROLL_COPY = 4'd5;
    localparam logic [3:0] S_SCROLL_FILL = 4'd6;
    localparam logic [3:0] S_READ_WAIT   = 4'd7;
    localparam logic [3:0] S_RESULT      = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.operation)
                    OP_PUT:
                    begin
                        if (st.is_newline || st.wrap_pending)
                        begin
                            cmd.cur_newline = 1'b1;
                            if (st.last_row)
                            begin
                                cmd.ptr_clear = 1'b1;
                                state_next    = S_SCROLL_PRIME;
                            end
                            else if (st.is_newline)
                            begin
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        else
                        begin
                            cmd.wr_sel      = WR_CHAR;
                            cmd.cur_advance = 1'b1;
                            state_next      = S_RESULT;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    OP_READ:
                    begin
                        if (st.idx_valid)
                        begin
                            cmd.rd_sel = RD_IDX;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            state_next = S_RESULT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_WRITE:
            begin
                cmd.wr_sel      = WR_CHAR;
                cmd.cur_advance = 1'b1;
                state_next      = S_RESULT;
            end
            S_CLEAR:
            begin
                cmd.wr_sel  = WR_BLANK;
                cmd.ptr_inc = 1'b1;
                if (st.last_cell)
                begin
                    cmd.cur_home = 1'b1;
                    state_next   = S_RESULT;
                end
            end
            S_SCROLL_PRIME:
            begin
                cmd.rd_sel = RD_SRC;
                state_next = S_SCROLL_COPY;
            end
            S_SCROLL_COPY:
            begin
                cmd.wr_sel  = WR_COPY;
                cmd.ptr_inc = 1'b1;
                if (st.last_copy)
                begin
                    state_next = S_SCROLL_FILL;
                end
                else
                begin
                    cmd.rd_sel = RD_SRC_NEXT;
                end
            end
            S_SCROLL_FILL:
            begin
                cmd.wr_sel  = WR_BLANK;
                cmd.ptr_inc = 1'b1;
                if (st.last_cell)
                begin
                    state_next = st.is_newline ? S_RESULT : S_WRITE;
                end
            end
            S_READ_WAIT:
            begin
                cmd.result    = 1'b1;
                cmd.take_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_RESULT:
            begin
                cmd.result = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_char_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_CHAR) |-> !st.wrap_pending)
        else $error("character written past end of row");

endmodule

[rtl/text_console_writer.sv]
// ============================================================================
// text_console_writer
// Text-mode console: screen memory of COLUMNS x ROWS character/color cells
// with cursor, line wrap, newline, scrolling, clear and cell read.
// ============================================================================
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off. Done is
// registered from the controller's result strobe: a plain put writes in the
// decode state, a wrapped put in the write state after the newline, and a read
// takes its data in the read-wait state. Clear writes one cell per cycle through
// the single screen memory write port. A newline or wrap on the last row scrolls
// by copying one cell per cycle through the memory's read and write ports and
// then blanking the bottom row; a wrapped character is written after that. Text
// color changes apply to cells written afterwards, blanks included. Clear the
// screen before reading cells.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  txc_pkg::txc_in_t             command,
    input  logic                         cfg_we,
    input  logic [txc_pkg::COLOR_W-1:0]  cfg_data,
    output logic                         done,
    output txc_pkg::txc_out_t            result
);
    import txc_pkg::*;

    txc_cmd_t  cmd;
    txc_stat_t st;

    txc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    txc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .command  (command),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .st       (st),
        .done     (done),
        .result   (result)
    );

endmodule

[tb/tb_text_console_writer.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_text_console_writer
// Self-checking bench for the text console writer. A directed table covers
// reset state, clear, out-of-range reads, field extremes and the unused
// opcode. Random line-shaped traffic follows, with wraps, newlines, scrolls,
// reads, clears and text color changes. Every result is checked against the
// table's expected value or an in-bench screen and cursor model.
// ============================================================================
module tb_text_console_writer;

    import txc_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int LIMIT   = 16_000_000;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct {
        txc_in_t  cmd;
        bit       typed;
        txc_out_t want;
    } plan_row_t;

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    txc_in_t            command  = '0;
    logic               cfg_we   = 1'b0;
    logic [COLOR_W-1:0] cfg_data = '0;
    logic               done;
    txc_out_t           result;

    logic [15:0]        screen_mem [CELLS];
    int                 cur_col;
    int                 cur_row;
    logic [COLOR_W-1:0] text_attr;

    txc_out_t           pending_results [$];
    plan_row_t          plan [$];
    int                 errors      = 0;
    int                 items_sent  = 0;
    int                 idle_pct    = 0;
    longint             cycle_count = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic txc_in_t make_cmd(logic [OP_W-1:0] op, int ch, int idx);
        txc_in_t c;
        c.operation  = op;
        c.char_code  = CHAR_W'(ch);
        c.cell_index = IDX_W'(idx);
        return c;
    endfunction

    function automatic plan_row_t plan_entry(logic [OP_W-1:0] op, int ch, int idx,
                                             bit typed, int pos, int rch, int rcol);
        plan_row_t r;
        r.cmd                  = make_cmd(op, ch, idx);
        r.typed                = typed;
        r.want.cursor_position = POS_W'(pos);
        r.want.read_char       = CHAR_W'(rch);
        r.want.read_color      = COLOR_W'(rcol);
        return r;
    endfunction

    task automatic line_feed();
        cur_col = 0;
        if (cur_row < ROWS - 1)
        begin
            cur_row++;
        end
        else
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_mem[i] = screen_mem[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen_mem[i] = {text_attr, BLANK_CODE};
        end
    endtask

    task automatic console_step(input txc_in_t it, output txc_out_t res);
        logic [15:0] cell_word;
        res = '0;
        case (it.operation)
            OP_PUT:
            begin
                if (it.char_code == NEWLINE_CODE)
                begin
                    line_feed();
                end
                else
                begin
                    if (cur_col >= COLUMNS)
                        line_feed();
                    screen_mem[cur_row * COLUMNS + cur_col] = {text_attr, it.char_code};
                    cur_col++;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_mem[i] = {text_attr, BLANK_CODE};
                cur_col = 0;
                cur_row = 0;
            end
            OP_READ:
            begin
                if (it.cell_index < CELLS)
                begin
                    cell_word      = screen_mem[it.cell_index];
                    res.read_char  = cell_word[7:0];
                    res.read_color = cell_word[15:8];
                end
            end
            default:
            begin
            end
        endcase
        res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    endtask

    task automatic send_item(input txc_in_t it, input bit typed, input txc_out_t typed_want);
        txc_out_t want;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        console_step(it, want);
        pending_results.push_back(typed ? typed_want : want);
        items_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_attr(input logic [COLOR_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        text_attr = value;
    endtask

    task automatic run_chunk(input int count);
        int target;
        int kind;
        int len;
        target = items_sent + count;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                len = $urandom_range(1, 100);
                if (len > target - items_sent)
                    len = target - items_sent;
                repeat (len)
                    send_item(make_cmd(OP_PUT, $urandom_range(0, 255),
                                       $urandom_range(0, 2047)), 1'b0, '0);
                if ($urandom_range(0, 1) == 1)
                    send_item(make_cmd(OP_PUT, NEWLINE_CODE, $urandom_range(0, 2047)),
                              1'b0, '0);
            end
            else if (kind < 82)
            begin
                len = $urandom_range(1, 4);
                if (len > target - items_sent)
                    len = target - items_sent;
                repeat (len)
                    send_item(make_cmd(OP_READ, $urandom_range(0, 255),
                                       ($urandom_range(0, 9) == 0) ?
                                       $urandom_range(CELLS, 2047) :
                                       $urandom_range(0, CELLS - 1)), 1'b0, '0);
            end
            else if (kind < 88)
            begin
                send_item(make_cmd(OP_NONE, $urandom_range(0, 255),
                                   $urandom_range(0, 2047)), 1'b0, '0);
            end
            else if (kind < 91)
            begin
                send_item(make_cmd(OP_CLEAR, $urandom_range(0, 255),
                                   $urandom_range(0, 2047)), 1'b0, '0);
            end
            else
            begin
                send_item(make_cmd(OP_PUT, NEWLINE_CODE, $urandom_range(0, 2047)), 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        txc_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.cursor_position !== want.cursor_position)
                begin
                    $display("%0t cursor_position expected %0d got %0d", $time,
                             want.cursor_position, result.cursor_position);
                    errors++;
                end
                if (result.read_char !== want.read_char)
                begin
                    $display("%0t read_char expected %h got %h", $time,
                             want.read_char, result.read_char);
                    errors++;
                end
                if (result.read_color !== want.read_color)
                begin
                    $display("%0t read_color expected %h got %h", $time,
                             want.read_color, result.read_color);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [COLOR_W-1:0] attr;
        cur_col   = 0;
        cur_row   = 0;
        text_attr = COLOR_RESET;
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = '0;

        // reset state, clear, out-of-range reads, extremes, unused opcode
        plan.push_back(plan_entry(OP_NONE,  8'hFF,        11'h7FF, 1, 0,  0,     0));
        plan.push_back(plan_entry(OP_CLEAR, 0,            0,       1, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            0,       1, 0,  32,    7));
        plan.push_back(plan_entry(OP_READ,  0,            1999,    1, 0,  32,    7));
        plan.push_back(plan_entry(OP_READ,  0,            2000,    1, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  8'hFF,        2047,    1, 0,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   8'hFF,        0,       1, 1,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   8'h00,        11'h7FF, 1, 2,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   NEWLINE_CODE, 0,       1, 80, 0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            0,       1, 80, 8'hFF, 7));
        plan.push_back(plan_entry(OP_READ,  0,            1,       1, 80, 8'h00, 7));
        plan.push_back(plan_entry(OP_READ,  0,            2,       1, 80, 32,    7));
        plan.push_back(plan_entry(OP_NONE,  8'h55,        11'h2AA, 1, 80, 0,     0));
        plan.push_back(plan_entry(OP_PUT,   8'hAA,        11'h555, 0, 0,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   8'h20,        0,       0, 0,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   NEWLINE_CODE, 0,       0, 0,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   NEWLINE_CODE, 0,       0, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            80,      0, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            81,      0, 0,  0,     0));
        plan.push_back(plan_entry(OP_CLEAR, 8'hFF,        11'h7FF, 0, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            80,      0, 0,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   8'h7F,        0,       0, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            11'h555, 0, 0,  0,     0));
        plan.push_back(plan_entry(OP_PUT,   8'h80,        0,       0, 0,  0,     0));
        plan.push_back(plan_entry(OP_READ,  0,            0,       0, 0,  0,     0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 26;
        foreach (plan[i])
            send_item(plan[i].cmd, plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:       attr = 8'h00;
                1:       attr = 8'hFF;
                4:       attr = 8'hF0;
                default: attr = COLOR_W'($urandom_range(0, 255));
            endcase
            set_attr(attr);
            idle_pct = (ph < 2) ? 26 : (ph < 4) ? 68 : 0;
            run_chunk(321);
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
